// ----- design/prg_pkg.sv -----
// Shared widths, codes and control types of the parabolic ramp generator.
package prg_pkg;

  localparam int RefW    = 32;   // Q16.16 reference
  localparam int TimeW   = 48;   // Q24.24 seconds
  localparam int LvlW    = 42;   // widened level arithmetic
  localparam int StW     = 54;   // signed time arithmetic
  localparam int SqArgW  = 36;
  localparam int SqQuoW  = 84;
  localparam int SqRootW = 42;
  localparam int SqRemW  = 46;
  localparam int SqCntW  = 7;
  localparam int MulW    = 128;
  localparam int McW     = 96;
  localparam int MpW     = 48;
  localparam int MulCntW = 6;
  localparam int DropLsb = 49;
  localparam int DropTop = 84;
  localparam int DropW   = 36;
  localparam int CfgIdxW = 2;
  localparam int InDataW = 80;
  localparam int OutUserW = 2;

  localparam logic [SqArgW-1:0] SqArgMax   = '1;
  localparam logic [DropW-1:0]  DropCap    = 36'h8_0000_0000;
  localparam logic [RefW-1:0]   AccelReset = 32'h0001_0000;
  localparam logic [RefW-1:0]   RefMax     = 32'h7FFF_FFFF;
  localparam logic [RefW-1:0]   RefMin     = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL = 2'd0,
    CFG_FINAL = 2'd1,
    CFG_DELAY = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_START_GO,
    ST_START_WAIT,
    ST_START_FIN,
    ST_SHIFT_GO,
    ST_SHIFT_WAIT,
    ST_SHIFT_FIN,
    ST_RT,
    ST_MUL_SQ,
    ST_MUL_ACC,
    ST_LEVEL,
    ST_GEN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_DIV,
    SQ_ROOT
  } sq_phase_e;

  typedef struct packed {
    logic load;
    logic bad;
    logic noramp;
    logic start_prep;
    logic sqrt_go;
    logic start_fin;
    logic tick_prep;
    logic shift_fin;
    logic rt;
    logic mul_step;
    logic mul2_load;
    logic level;
    logic pre;
    logic gen;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic accel_zero;
    logic no_ramp;
    logic pre_delay;
    logic need_sqrt;
    logic ended;
    logic sqrt_done;
    logic mul_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- design/parabolic_ramp_generator.sv -----
// Top level of the parabolic ramp generator: controller, datapath and port wiring.
//
// Input stream (s_axis_*): tuser selects the item kind, 0 starts a new ramp from the
// reference in tdata, 1 is a time tick carrying the current time and the fed-back,
// rate-limited reference. Each accepted item yields exactly one result item on
// m_axis_*: the generated reference in tdata, running and bad_param in tuser.
// Configuration (cfg_*): index 0 acceleration, 1 final reference, 2 start delay; writes
// are always taken and must only be made while no item is in flight.
// Items are processed one at a time. A start runs the bit-serial divider and then the
// root extraction. A tick runs the two 48-step passes of the shift-add multiplier,
// after a divide and root extraction when the fed-back value forces a new time shift.
// A zero-acceleration start, or a tick before the delay or with no ramp loaded, skips
// the divider and the multiplier.
// A finished result waits in the output register while the next item is taken in;
// if the receiver still stalls when that item is done, the block holds it.
// Reset clears the configuration to its defaults and unloads any ramp, so ticks give
// zero until the next start.
module parabolic_ramp_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [prg_pkg::InDataW-1:0]       s_axis_tdata,  // time_now, ref_in
  input  logic                              s_axis_tuser,  // func
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [prg_pkg::RefW-1:0]          m_axis_tdata,  // ref_out
  output logic [prg_pkg::OutUserW-1:0]      m_axis_tuser,  // running, bad_param
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prg_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [prg_pkg::TimeW-1:0]         cfg_data_i
);
  import prg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  prg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ----- design/prg_sqrt.sv -----
// Bit-serial unit for floor(2^24 * sqrt(n / a)): restoring divide, then digit-by-digit root.
module prg_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [prg_pkg::SqArgW-1:0]  arg_i,
  input  logic [prg_pkg::RefW-1:0]    accel_i,
  output logic                        done_o,
  output logic [prg_pkg::SqRootW-1:0] root_o
);
  import prg_pkg::*;

  sq_phase_e            phase_q, phase_d;
  logic [SqCntW-1:0]    cnt_q, cnt_d;
  logic                 done_q;
  logic [RefW-1:0]      rem_q;
  logic [SqQuoW-1:0]    divd_q, quo_q;
  logic [SqRemW-1:0]    srem_q;
  logic [SqRootW-1:0]   root_q;

  logic [RefW:0]        rem_t, rem_n;
  logic                 div_ge;
  logic [SqRemW-1:0]    srem_t, trial;
  logic                 root_ge;

  assign rem_t  = {rem_q, divd_q[SqQuoW-1]};
  assign div_ge = rem_t >= {1'b0, accel_i};
  assign rem_n  = div_ge ? rem_t - {1'b0, accel_i} : rem_t;

  assign srem_t  = {srem_q[SqRemW-3:0], quo_q[SqQuoW-1:SqQuoW-2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign root_ge = srem_t >= trial;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (phase_q)
      SQ_IDLE: begin
        if (go_i) begin
          phase_d = SQ_DIV;
          cnt_d   = SqCntW'(SqQuoW - 1);
        end
      end
      SQ_DIV: begin
        if (cnt_q == '0) begin
          phase_d = SQ_ROOT;
          cnt_d   = SqCntW'(SqRootW - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SQ_ROOT: begin
        if (cnt_q == '0) begin
          phase_d = SQ_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: phase_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= SQ_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= (phase_q == SQ_ROOT) && (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      SQ_IDLE: begin
        if (go_i) begin
          divd_q <= {arg_i, {(SqQuoW - SqArgW){1'b0}}};
          rem_q  <= '0;
          quo_q  <= '0;
        end
      end
      SQ_DIV: begin
        rem_q  <= rem_n[RefW-1:0];
        divd_q <= {divd_q[SqQuoW-2:0], 1'b0};
        quo_q  <= {quo_q[SqQuoW-2:0], div_ge};
        if (cnt_q == '0) begin
          srem_q <= '0;
          root_q <= '0;
        end
      end
      SQ_ROOT: begin
        srem_q <= root_ge ? srem_t - trial : srem_t;
        root_q <= {root_q[SqRootW-2:0], root_ge};
        quo_q  <= {quo_q[SqQuoW-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  // Zero acceleration gives a zero time.
  assign root_o = (accel_i == '0) ? '0 : root_q;

endmodule

// ----- design/prg_dp.sv -----
// Datapath: registers, ramp state, level arithmetic, serial multiplier and output register.
module prg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prg_pkg::dp_cmd_t              cmd_i,
  output prg_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_valid_i,
  input  logic [prg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [prg_pkg::TimeW-1:0]     cfg_data_i,
  input  logic [prg_pkg::InDataW-1:0]   in_data_i,
  input  logic                          in_user_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prg_pkg::RefW-1:0]      out_data_o,
  output logic [prg_pkg::OutUserW-1:0]  out_user_o
);
  import prg_pkg::*;

  // configuration and reset-critical state
  logic [RefW-1:0]         acc_q, al_q;
  logic signed [RefW-1:0]  fin_q;
  logic [TimeW-1:0]        dly_q, pt_q;
  logic                    ovalid_q;

  // ramp state
  logic                    asc_q;
  logic signed [RefW:0]    mir_q;
  logic signed [LvlW-1:0]  lvs_q, lvj_q, lve_q, lvl_q;
  logic [TimeW-1:0]        tj_q, te_q;
  logic signed [StW-1:0]   tsh_q;
  logic signed [RefW-1:0]  pg_q, pr_q;

  // item and working registers
  logic                    func_q;
  logic [TimeW-1:0]        now_q;
  logic signed [RefW-1:0]  fed_q;
  logic [SqArgW-1:0]       sqarg_q;
  logic                    shj_q, seg_q, big_q, run_q;
  logic [McW-1:0]          mc_q;
  logic [MpW-1:0]          mp_q;
  logic [MulW-1:0]         prod_q;
  logic [MulCntW-1:0]      cnt_q;
  logic [RefW-1:0]         res_ref_q, oref_q;
  logic                    res_run_q, res_bad_q, orun_q, obad_q;

  logic [SqRootW-1:0]      root;
  logic                    sqrt_done;

  logic signed [LvlW-1:0]  fed_w, fin_w, mir_w, delta_w, absd_w, init_w, rn_w;
  logic signed [LvlW-1:0]  shj_w, shd_w, sh_sel, d_w, gen_w;
  logic                    asc_n, ge_start, ge_join, ge_end, changed, gen_ovf;
  logic [SqArgW-1:0]       sh_arg;
  logic signed [StW-1:0]   now_s, dly_s, tj_s, te_s, pt_s, root_s, base_s;
  logic signed [StW-1:0]   rt_s, t_sel, u_s;
  logic                    le_join, lt_end, big_w;
  logic [MulW-1:0]         prod_n;
  logic [DropW-1:0]        drop_w;
  logic [RefW-1:0]         gen32;

  prg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (cmd_i.sqrt_go),
    .arg_i   (sqarg_q),
    .accel_i (al_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // level side
  assign fed_w   = {{(LvlW - RefW){fed_q[RefW-1]}}, fed_q};
  assign fin_w   = {{(LvlW - RefW){fin_q[RefW-1]}}, fin_q};
  assign mir_w   = {{(LvlW - RefW - 1){mir_q[RefW]}}, mir_q};
  assign delta_w = fed_w - fin_w;
  assign asc_n   = delta_w[LvlW-1];
  assign absd_w  = asc_n ? -delta_w : delta_w;
  assign init_w  = asc_n ? (fin_w + fin_w - fed_w) : fed_w;

  assign rn_w     = asc_q ? mir_w - fed_w : fed_w;
  assign ge_start = rn_w >= lvs_q;
  assign ge_join  = rn_w >= lvj_q;
  assign ge_end   = rn_w >= lve_q;
  assign changed  = (fed_q != pg_q) && (fed_q != pr_q);
  assign shj_w    = (lvs_q - rn_w) <<< 1;
  assign shd_w    = (rn_w - lve_q) <<< 1;
  assign sh_sel   = ge_join ? shj_w : shd_w;
  assign sh_arg   = (|sh_sel[LvlW-1:SqArgW]) ? SqArgMax : sh_sel[SqArgW-1:0];

  // time side
  assign now_s  = {{(StW - TimeW){1'b0}}, now_q};
  assign dly_s  = {{(StW - TimeW){1'b0}}, dly_q};
  assign tj_s   = {{(StW - TimeW){1'b0}}, tj_q};
  assign te_s   = {{(StW - TimeW){1'b0}}, te_q};
  assign pt_s   = {{(StW - TimeW){1'b0}}, pt_q};
  assign root_s = {{(StW - SqRootW){1'b0}}, root};
  assign base_s = pt_s - dly_s;
  assign rt_s   = now_s - dly_s - tsh_q;
  assign le_join = rt_s <= tj_s;
  assign lt_end  = rt_s < te_s;
  assign t_sel   = le_join ? rt_s : rt_s - te_s;
  assign u_s     = t_sel[StW-1] ? -t_sel : t_sel;
  assign big_w   = |u_s[StW-1:MpW];

  // shift-add multiplier, multiplier MSB first
  assign prod_n = {prod_q[MulW-2:0], 1'b0} +
                  (mp_q[MpW-1] ? {{(MulW - McW){1'b0}}, mc_q} : {MulW{1'b0}});

  assign drop_w = (big_q || (|prod_q[MulW-1:DropTop])) ? DropCap :
                  {1'b0, prod_q[DropTop-1:DropLsb]};
  assign d_w    = {{(LvlW - DropW){1'b0}}, drop_w};

  assign gen_w   = (run_q && asc_q) ? mir_w - lvl_q : lvl_q;
  assign gen_ovf = !((&gen_w[LvlW-1:RefW-1]) || !(|gen_w[LvlW-1:RefW-1]));
  assign gen32   = gen_ovf ? (gen_w[LvlW-1] ? RefMin : RefMax) : gen_w[RefW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= AccelReset;
      fin_q    <= '0;
      dly_q    <= '0;
      al_q     <= '0;
      pt_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ACCEL: acc_q <= cfg_data_i[RefW-1:0];
          CFG_FINAL: fin_q <= cfg_data_i[RefW-1:0];
          CFG_DELAY: dly_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start_prep) al_q <= acc_q;
      if (cmd_i.gen)        pt_q <= now_q;
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_user_i;
      now_q  <= in_data_i[TimeW-1:0];
      fed_q  <= in_data_i[InDataW-1:TimeW];
    end
    if (cmd_i.bad) begin
      res_ref_q <= fed_q;
      res_run_q <= 1'b0;
      res_bad_q <= 1'b1;
    end
    if (cmd_i.noramp) begin
      res_ref_q <= '0;
      res_run_q <= 1'b0;
      res_bad_q <= 1'b0;
    end
    if (cmd_i.start_prep) begin
      asc_q   <= asc_n;
      mir_q   <= {fin_q, 1'b0};
      tsh_q   <= '0;
      pg_q    <= fed_q;
      pr_q    <= fed_q;
      lvs_q   <= init_w;
      lvj_q   <= init_w - (absd_w >>> 1);
      lve_q   <= fin_w;
      sqarg_q <= absd_w[SqArgW-1:0];
    end
    if (cmd_i.start_fin) begin
      tj_q      <= {{(TimeW - SqRootW){1'b0}}, root};
      te_q      <= {{(TimeW - SqRootW - 1){1'b0}}, root, 1'b0};
      res_ref_q <= fed_q;
      res_run_q <= 1'b1;
      res_bad_q <= 1'b0;
    end
    if (cmd_i.tick_prep) begin
      // A changed fed-back value at or above the start level restarts the ramp clock.
      if (changed && ge_start) tsh_q <= '0;
      sqarg_q <= sh_arg;
      shj_q   <= ge_join;
    end
    if (cmd_i.shift_fin) begin
      tsh_q <= shj_q ? base_s - root_s : base_s - (te_s - root_s);
    end
    if (cmd_i.rt) begin
      seg_q  <= !le_join;
      big_q  <= big_w;
      lvl_q  <= lve_q;
      run_q  <= le_join || lt_end;
      mc_q   <= {{(McW - MpW){1'b0}}, u_s[MpW-1:0]};
      mp_q   <= u_s[MpW-1:0];
      prod_q <= '0;
      cnt_q  <= MulCntW'(MpW);
    end
    if (cmd_i.mul_step) begin
      prod_q <= prod_n;
      mp_q   <= {mp_q[MpW-2:0], 1'b0};
      cnt_q  <= cnt_q - 1'b1;
    end
    if (cmd_i.mul2_load) begin
      mc_q   <= prod_q[McW-1:0];
      mp_q   <= {{(MpW - RefW){1'b0}}, al_q};
      prod_q <= '0;
      cnt_q  <= MulCntW'(MpW);
    end
    if (cmd_i.level) begin
      lvl_q <= seg_q ? lve_q + d_w : lvs_q - d_w;
    end
    if (cmd_i.pre) begin
      lvl_q <= lvs_q;
      run_q <= 1'b1;
    end
    if (cmd_i.gen) begin
      pr_q      <= fed_q;
      pg_q      <= gen32;
      res_ref_q <= gen32;
      res_run_q <= run_q;
      res_bad_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      oref_q <= res_ref_q;
      orun_q <= res_run_q;
      obad_q <= res_bad_q;
    end
  end

  always_comb begin
    stat_o.func       = func_q;
    stat_o.accel_zero = (acc_q == '0);
    stat_o.no_ramp    = (al_q == '0);
    stat_o.pre_delay  = now_q < dly_q;
    stat_o.need_sqrt  = changed && !ge_start && (ge_join || ge_end);
    stat_o.ended      = !le_join && !lt_end;
    stat_o.sqrt_done  = sqrt_done;
    stat_o.mul_done   = (cnt_q == '0);
    stat_o.out_free   = !ovalid_q || out_ready_i;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = oref_q;
  assign out_user_o  = {obad_q, orun_q};

endmodule

// ----- design/prg_ctrl.sv -----
// Controller: sequences start and tick items through the datapath.
module prg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prg_pkg::dp_stat_t stat_i,
  output prg_pkg::dp_cmd_t  cmd_o
);
  import prg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!stat_i.func) begin
          state_d = stat_i.accel_zero ? ST_EMIT : ST_START_GO;
        end else if (stat_i.no_ramp) begin
          state_d = ST_EMIT;
        end else if (stat_i.pre_delay) begin
          state_d = ST_GEN;
        end else begin
          state_d = stat_i.need_sqrt ? ST_SHIFT_GO : ST_RT;
        end
      end
      ST_START_GO:   state_d = ST_START_WAIT;
      ST_START_WAIT: if (stat_i.sqrt_done) state_d = ST_START_FIN;
      ST_START_FIN:  state_d = ST_EMIT;
      ST_SHIFT_GO:   state_d = ST_SHIFT_WAIT;
      ST_SHIFT_WAIT: if (stat_i.sqrt_done) state_d = ST_SHIFT_FIN;
      ST_SHIFT_FIN:  state_d = ST_RT;
      ST_RT:         state_d = stat_i.ended ? ST_GEN : ST_MUL_SQ;
      ST_MUL_SQ:     if (stat_i.mul_done) state_d = ST_MUL_ACC;
      ST_MUL_ACC:    if (stat_i.mul_done) state_d = ST_LEVEL;
      ST_LEVEL:      state_d = ST_GEN;
      ST_GEN:        state_d = ST_EMIT;
      ST_EMIT:       if (stat_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DISPATCH: begin
        if (!stat_i.func) begin
          cmd_o.bad        = stat_i.accel_zero;
          cmd_o.start_prep = !stat_i.accel_zero;
        end else if (stat_i.no_ramp) begin
          cmd_o.noramp = 1'b1;
        end else if (stat_i.pre_delay) begin
          cmd_o.pre = 1'b1;
        end else begin
          cmd_o.tick_prep = 1'b1;
        end
      end
      ST_START_GO,
      ST_SHIFT_GO:   cmd_o.sqrt_go = 1'b1;
      ST_START_FIN:  cmd_o.start_fin = 1'b1;
      ST_SHIFT_FIN:  cmd_o.shift_fin = 1'b1;
      ST_RT:         cmd_o.rt = 1'b1;
      ST_MUL_SQ: begin
        cmd_o.mul2_load = stat_i.mul_done;
        cmd_o.mul_step  = !stat_i.mul_done;
      end
      ST_MUL_ACC:    cmd_o.mul_step = !stat_i.mul_done;
      ST_LEVEL:      cmd_o.level = 1'b1;
      ST_GEN:        cmd_o.gen = 1'b1;
      ST_EMIT:       cmd_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sim/parabolic_ramp_generator_tb.sv -----
// Self-checking testbench of the parabolic ramp generator with an in-bench predictor.
`timescale 1ns / 100ps

module parabolic_ramp_generator_tb;
  import prg_pkg::*;

  localparam longint unsigned Mask48   = 64'hFFFF_FFFF_FFFF;
  localparam longint          CapDrop  = 64'h8_0000_0000;
  localparam int              Settle   = 400;

  typedef enum int {FB_RAW, FB_ECHO, FB_NUDGE} feedback_e;

  typedef struct {
    bit              func;
    longint unsigned when;
    logic [31:0]     level;
    feedback_e       fb;
  } ramp_item_t;

  typedef struct {
    logic [31:0] ref_val;
    logic        running;
    logic        bad;
  } ramp_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [RefW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [TimeW-1:0] cfg_data_i = '0;

  parabolic_ramp_generator u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor configuration and state
  longint unsigned pr_accel, pr_delay, pr_tjoin, pr_tend, pr_ptime, pr_alatch;
  longint          pr_final, pr_mirror, pr_lstart, pr_ljoin, pr_lend, pr_shift;
  longint          pr_pgen, pr_prec;
  bit              pr_asc;

  ramp_item_t pending_items[$];
  ramp_out_t  expected_outs[$];
  int errors = 0;
  bit calm = 0;
  bit in_took = 0;
  int in_gap = 0, out_gap = 0;
  longint unsigned tcur;

  function automatic longint sext32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(2^24 * sqrt(n / a)) with the latched acceleration
  function automatic longint unsigned root_time(longint unsigned n);
    logic [127:0] quo, c;
    logic [42:0]  r;
    int i;
    if (pr_alatch == 0) return 0;
    if (n > 64'hF_FFFF_FFFF) n = 64'hF_FFFF_FFFF;
    quo = (128'(n) << 48) / 128'(pr_alatch);
    r = '0;
    for (i = 42; i >= 0; i--) begin
      c = 128'(r | (43'd1 << i));
      if (c * c <= quo) r = c[42:0];
    end
    return longint'(r);
  endfunction

  function automatic longint parabola_drop(longint t);
    longint unsigned u;
    logic [127:0] p;
    u = (t < 0) ? longint'(-t) : t;
    if (u >= 64'h1_0000_0000_0000) return CapDrop;
    p = 128'(u) * 128'(u);
    p = p * 128'(pr_alatch);
    if ((p >> 84) != 0) return CapDrop;
    return longint'(p >> 49);
  endfunction

  function automatic ramp_out_t predict_ramp(bit func, longint unsigned now, longint fed);
    ramp_out_t o;
    longint delta, init, lvl, gen, rn, base, rt;
    bit run;
    o.bad = 1'b0;
    run = 1'b1;
    if (!func) begin
      o.ref_val = fed[31:0];
      if (pr_accel == 0) begin
        o.running = 1'b0;
        o.bad = 1'b1;
        return o;
      end
      pr_alatch = pr_accel;
      pr_shift = 0;
      pr_pgen = fed;
      pr_prec = fed;
      pr_mirror = 2 * pr_final;
      init = fed;
      delta = init - pr_final;
      pr_asc = delta < 0;
      if (pr_asc) begin
        init = pr_mirror - init;
        delta = -delta;
      end
      pr_tjoin = root_time(delta);
      pr_tend = 2 * pr_tjoin;
      pr_lstart = init;
      pr_ljoin = init - (delta >>> 1);
      pr_lend = pr_final;
      o.running = 1'b1;
      return o;
    end
    if (pr_alatch == 0) begin
      o.ref_val = '0;
      o.running = 1'b0;
      return o;
    end
    if (now < pr_delay) begin
      lvl = pr_lstart;
    end else begin
      if (fed != pr_pgen && fed != pr_prec) begin
        rn = pr_asc ? pr_mirror - fed : fed;
        base = longint'(pr_ptime) - longint'(pr_delay);
        if (rn >= pr_lstart)
          pr_shift = 0;
        else if (rn >= pr_ljoin)
          pr_shift = base - longint'(root_time(2 * (pr_lstart - rn)));
        else if (rn >= pr_lend)
          pr_shift = base - (longint'(pr_tend) - longint'(root_time(2 * (rn - pr_lend))));
      end
      rt = longint'(now) - longint'(pr_delay) - pr_shift;
      if (rt <= longint'(pr_tjoin))
        lvl = pr_lstart - parabola_drop(rt);
      else if (rt < longint'(pr_tend))
        lvl = pr_lend + parabola_drop(rt - longint'(pr_tend));
      else begin
        lvl = pr_lend;
        run = 1'b0;
      end
    end
    pr_prec = fed;
    gen = (run && pr_asc) ? sat32(pr_mirror - lvl) : sat32(lvl);
    pr_pgen = gen;
    pr_ptime = now;
    o.ref_val = gen[31:0];
    o.running = run;
    return o;
  endfunction

  // sender
  always @(negedge clk_i) begin
    ramp_item_t it;
    logic [31:0] fed;
    logic vld;
    vld = s_axis_tvalid;
    if (rst_ni && !(s_axis_tvalid && !in_took)) begin
      in_took = 0;
      vld = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        case (it.fb)
          FB_ECHO:  fed = pr_pgen[31:0];
          FB_NUDGE: fed = pr_pgen[31:0] + it.level;
          default:  fed = it.level;
        endcase
        s_axis_tdata <= {fed, it.when[47:0]};
        s_axis_tuser <= it.func;
        vld = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 5);
      end
    end
    s_axis_tvalid <= vld;
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
    end
  end

  // monitor: predict on each accepted item, check each result
  always @(posedge clk_i) begin
    ramp_out_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ACCEL: pr_accel = cfg_data_i[31:0];
          CFG_FINAL: pr_final = sext32(cfg_data_i[31:0]);
          CFG_DELAY: pr_delay = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_took = 1;
        expected_outs.push_back(predict_ramp(s_axis_tuser, s_axis_tdata[47:0],
                                             sext32(s_axis_tdata[79:48])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outs.size() == 0) begin
          $display("%0t: unexpected result ref %h tuser %b", $time, m_axis_tdata,
                   m_axis_tuser);
          errors++;
        end else begin
          e = expected_outs.pop_front();
          if (m_axis_tdata !== e.ref_val) begin
            $display("%0t: ref_out expected %h actual %h", $time, e.ref_val, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser[0] !== e.running) begin
            $display("%0t: running expected %b actual %b", $time, e.running,
                     m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[1] !== e.bad) begin
            $display("%0t: bad_param expected %b actual %b", $time, e.bad, m_axis_tuser[1]);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_item(bit func, longint unsigned when, logic [31:0] level, feedback_e fb);
    ramp_item_t it;
    it.func = func;
    it.when = when & Mask48;
    it.level = level;
    it.fb = fb;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !s_axis_tvalid && expected_outs.size() == 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[47:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one ramp setting followed by well-formed runs with random feedback
  task automatic run_phase(longint unsigned acc, logic [31:0] fin, longint unsigned dly_off,
                           int n, int spread);
    int k, j, pick;
    longint unsigned dt;
    logic [31:0] lvl;
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_FINAL, fin);
    write_reg(CFG_DELAY, (tcur + dly_off) & Mask48);
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) lvl = $urandom;
      else if (pick == 1) lvl = 32'h7FFF_FFFF;
      else if (pick == 2) lvl = 32'h8000_0000;
      else lvl = fin + $signed($urandom_range(0, 2 * spread)) - spread;
      add_item(1'b0, tcur, lvl, FB_RAW);
      k++;
      for (j = $urandom_range(3, 14); j > 0 && k < n; j--) begin
        dt = $urandom_range(0, 3) == 0 ? {$urandom_range(0, 63), $urandom} : $urandom;
        tcur = (tcur + dt) & Mask48;
        pick = $urandom_range(0, 9);
        if (pick < 6)
          add_item(1'b1, tcur, '0, FB_ECHO);
        else if (pick < 9)
          add_item(1'b1, tcur, $signed($urandom_range(0, 2 * spread)) - spread, FB_NUDGE);
        else
          add_item(1'b1, tcur, $urandom, FB_RAW);
        k++;
      end
    end
    drain();
  endtask

  initial begin
    int p;
    pr_accel = 65536; pr_final = 0; pr_delay = 0;
    pr_asc = 0; pr_mirror = 0; pr_lstart = 0; pr_ljoin = 0; pr_lend = 0;
    pr_tjoin = 0; pr_tend = 0; pr_shift = 0; pr_ptime = 0;
    pr_pgen = 0; pr_prec = 0; pr_alatch = 0;
    tcur = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ticks with no ramp loaded, then a start with zero acceleration
    add_item(1'b1, 0, 32'h7FFF_FFFF, FB_RAW);
    add_item(1'b1, Mask48, 32'h8000_0000, FB_RAW);
    drain();
    write_reg(CFG_ACCEL, 0);
    add_item(1'b0, 0, 32'h1234_5678, FB_RAW);
    add_item(1'b1, 100, 32'h0, FB_RAW);
    drain();
    // default settings: descending and ascending ramps, past the end, feedback jumps
    write_reg(CFG_ACCEL, 65536);
    add_item(1'b0, 0, 32'h0004_0000, FB_RAW);
    add_item(1'b1, 64'h0100_0000, '0, FB_ECHO);
    add_item(1'b1, 64'h0180_0000, 32'h0000_8000, FB_NUDGE);
    add_item(1'b1, 64'h0200_0000, 32'h0003_0000, FB_RAW);
    add_item(1'b1, 64'h0300_0000, 32'hFFFF_0000, FB_RAW);
    add_item(1'b1, 64'h0400_0000, '0, FB_ECHO);
    add_item(1'b1, 64'h2000_0000, '0, FB_ECHO);
    add_item(1'b0, 64'h2000_0000, 32'hFFFC_0000, FB_RAW);
    add_item(1'b1, 64'h2100_0000, '0, FB_ECHO);
    add_item(1'b1, 64'h2180_0000, 32'hFFFD_8000, FB_RAW);
    add_item(1'b1, 64'h2200_0000, 32'hFFFF_F000, FB_RAW);
    add_item(1'b0, 64'h2200_0000, 32'h7FFF_FFFF, FB_RAW);
    add_item(1'b1, 64'h2300_0000, '0, FB_ECHO);
    add_item(1'b0, 64'h2300_0000, 32'h8000_0000, FB_RAW);
    add_item(1'b1, Mask48, '0, FB_ECHO);
    drain();
    tcur = 0;

    // settings sweep, extremes first
    run_phase(65536, 32'h8000_0000, 0, 30, 1 << 20);
    run_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 30, 1 << 24);
    run_phase(1, 0, 64'h0400_0000, 30, 1 << 16);
    run_phase(0, $urandom, 0, 10, 1 << 16);
    tcur = 64'hFFFF_F000_0000;
    run_phase(65536, $urandom, 0, 30, 1 << 20);
    tcur = 0;
    run_phase($urandom, $urandom, Mask48, 20, 1 << 20);
    for (p = 0; p < 15; p++) begin
      if (p == 12) calm = 1;
      tcur = $urandom_range(0, 3) == 0 ? {$urandom_range(0, 255), $urandom, 8'h0} : 0;
      run_phase($urandom_range(0, 1) ? $urandom_range(1 << 12, 1 << 20) : $urandom,
                $urandom, $urandom_range(0, 2) == 0 ? $urandom : 0, 40,
                1 << $urandom_range(12, 26));
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
